// ===== rtl/emfl_pkg.sv =====
package emfl_pkg;

	// Window of stored distances
	localparam int WINDOW = 10;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int IDX_W  = $clog2(WINDOW);

	// Field widths
	localparam int ECHO_W = 17;
	localparam int TIME_W = 64;
	localparam int DIST_W = 11;
	localparam int PCT_W  = 7;
	localparam int DB_W   = 7;
	localparam int IVL_W  = 32;
	localparam int MINS_W = 5;
	localparam int LAST_W = 8;

	// Configuration port
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int DATA_W    = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FULL        = 3'd0,
		REG_EMPTY       = 3'd1,
		REG_DEADBAND    = 3'd2,
		REG_INTERVAL    = 3'd3,
		REG_MIN_SAMPLES = 3'd4
	} reg_idx_t;

	localparam logic [DIST_W-1:0] FULL_RST        = 11'd55;
	localparam logic [DIST_W-1:0] EMPTY_RST       = 11'd5;
	localparam logic [DB_W-1:0]   DEADBAND_RST    = 7'd10;
	localparam logic [IVL_W-1:0]  INTERVAL_RST    = 32'd2000000;
	localparam logic [MINS_W-1:0] MIN_SAMPLES_RST = 5'd3;
	localparam logic [LAST_W-1:0] LAST_PCT_RST    = 8'hFF;

	// Echo width to centimeters: width * 1715 / 100000.
	// The divide is (x >> 5) / 3125, done as a multiply by ceil(2^35 / 3125).
	localparam int ECHO_MUL_W = 11;
	localparam logic [ECHO_MUL_W-1:0] ECHO_MUL = 11'd1715;
	localparam int PROD1_W = ECHO_W + ECHO_MUL_W;
	localparam int PRE_SH  = 5;
	localparam int Y_W     = PROD1_W - PRE_SH;
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP = 24'd10995117;
	localparam int PROD2_W = Y_W + RECIP_W;
	localparam int POST_SH = 35;
	localparam int DQ_W    = PROD2_W - POST_SH;
	localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

	// Percent mapping and its divider
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam int QUOT_W = 7;
	localparam int NUM_W  = DIST_W + QUOT_W;
	localparam int SUB_W  = DIST_W + QUOT_W - 1;
	localparam int STEP_W = $clog2(QUOT_W);

	typedef struct packed {
		logic [ECHO_W-1:0] echo_width_us;
		logic [TIME_W-1:0] now_us;
	} sample_t;

	typedef struct packed {
		logic [PCT_W-1:0]  fill_pct;
		logic [DIST_W-1:0] median_cm;
	} level_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/emfl_cell.sv =====
module emfl_cell import emfl_pkg::*; (
	input  logic              clk,
	input  logic              shift,
	input  logic [DIST_W-1:0] din,
	output logic [DIST_W-1:0] dout,
	input  logic [DIST_W-1:0] cand,
	input  logic              earlier,
	input  logic              occupied,
	output logic              lt
);

	logic [DIST_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= din;
		end
	end

	assign dout = value_q;

	// Ties break by position so that exactly one candidate gets each rank
	assign lt = occupied & ((value_q < cand) | ((value_q == cand) & earlier));

endmodule

// ===== rtl/emfl_div.sv =====
module emfl_div import emfl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DIST_W-1:0] den,
	output logic [QUOT_W-1:0] quot,
	output div_status_t       status
);

	logic [NUM_W-1:0]  rem_q;
	logic [SUB_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  dsh_ext;
	logic              fits;

	assign dsh_ext = NUM_W'(dsh_q);
	assign fits    = rem_q >= dsh_ext;

	// Restoring division, one quotient bit per cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dsh_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				rem_q  <= num;
				dsh_q  <= {den, {(QUOT_W-1){1'b0}}};
				quot_q <= '0;
				step_q <= STEP_W'(QUOT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - dsh_ext;
				end
				quot_q <= {quot_q[QUOT_W-2:0], fits};
				dsh_q  <= dsh_q >> 1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign quot   = quot_q;
	assign status = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/echo_median_fill_level_gate_unit.sv =====
// A posting word raises level_valid after these steps in order: convert and store (S_CONV1,
// S_CONV2, S_STORE), the rank scan, the percent map, the divide when not clamped, and the gate.
// Throughput: one word at a time; sample_stall stays high until the sequencer is back in S_IDLE,
// and a stalled level word holds the next one back. Words short of min_samples end at the store.
// Reset: asynchronous, active low; registers return to their defaults, the window is empty and
// the first filtered word always posts.
module echo_median_fill_level_gate_unit import emfl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// echo samples in
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	// fill levels out
	output logic              level_valid,
	input  logic              level_stall,
	output level_t            level
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV1,
		S_CONV2,
		S_STORE,
		S_RANK,
		S_PCT,
		S_DIV,
		S_DECIDE
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DIST_W-1:0] full_q;
	logic [DIST_W-1:0] empty_q;
	logic [DB_W-1:0]   deadband_q;
	logic [IVL_W-1:0]  interval_q;
	logic [MINS_W-1:0] min_samples_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q        <= FULL_RST;
			empty_q       <= EMPTY_RST;
			deadband_q    <= DEADBAND_RST;
			interval_q    <= INTERVAL_RST;
			min_samples_q <= MIN_SAMPLES_RST;
		end else if (cfg_wr) begin
			// Byte address 4*i; low address bits ignored, unknown indexes dropped
			unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_FULL:        full_q        <= pwdata[DIST_W-1:0];
				REG_EMPTY:       empty_q       <= pwdata[DIST_W-1:0];
				REG_DEADBAND:    deadband_q    <= pwdata[DB_W-1:0];
				REG_INTERVAL:    interval_q    <= pwdata[IVL_W-1:0];
				REG_MIN_SAMPLES: min_samples_q <= pwdata[MINS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
			REG_FULL:        prdata = DATA_W'(full_q);
			REG_EMPTY:       prdata = DATA_W'(empty_q);
			REG_DEADBAND:    prdata = DATA_W'(deadband_q);
			REG_INTERVAL:    prdata = DATA_W'(interval_q);
			REG_MIN_SAMPLES: prdata = DATA_W'(min_samples_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state and datapath registers
	// ------------------------------------------------------------------
	state_t             state_q;
	sample_t            sample_q;
	logic [PROD1_W-1:0] prod1_s1;
	logic [PROD2_W-1:0] prod2_s2;
	logic [TIME_W-1:0]  elapsed_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   k_q;
	logic [DIST_W-1:0]  med_q;
	logic [PCT_W-1:0]   pct_q;
	logic [LAST_W-1:0]  last_pct_q;
	logic [TIME_W-1:0]  last_time_q;
	logic               level_valid_q;
	level_t             level_q;

	logic accept;
	assign sample_stall = state_q != S_IDLE;
	assign accept       = sample_valid & ~sample_stall;

	// ------------------------------------------------------------------
	// Distance: drop the reciprocal product's fraction, clamp to 11 bits
	// ------------------------------------------------------------------
	logic [DQ_W-1:0]   dist_raw;
	logic [DIST_W-1:0] dist_sat;

	assign dist_raw = prod2_s2[PROD2_W-1:POST_SH];
	assign dist_sat = (dist_raw > DQ_W'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];

	// Fill count saturates at the window size; the oldest word falls off the end
	logic [CNT_W-1:0] count_next;
	logic             enough;

	assign count_next = (count_q == CNT_W'(WINDOW)) ? count_q : count_q + 1'b1;
	assign enough     = MINS_W'(count_next) >= min_samples_q;

	// ------------------------------------------------------------------
	// Row of cells: a shift line of the newest WINDOW distances, newest in
	// cell 0. During the rank scan one cell's value is broadcast as the
	// candidate; every occupied cell reports whether it sorts below it.
	// The candidate whose rank equals count/2 is the (upper) median.
	// ------------------------------------------------------------------
	logic [DIST_W-1:0] cell_val [WINDOW];
	logic [WINDOW-1:0] lt_vec;
	logic [DIST_W-1:0] cand;
	logic              shift;
	logic [CNT_W-1:0]  rank;
	logic              hit;

	assign shift = state_q == S_STORE;
	assign cand  = cell_val[k_q];

	for (genvar j = 0; j < WINDOW; j++) begin : g_cell
		logic [DIST_W-1:0] din;
		if (j == 0) begin : g_head
			assign din = dist_sat;
		end else begin : g_link
			assign din = cell_val[j-1];
		end
		emfl_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.din      (din),
			.dout     (cell_val[j]),
			.cand     (cand),
			.earlier  (IDX_W'(j) < k_q),
			.occupied (CNT_W'(j) < count_q),
			.lt       (lt_vec[j])
		);
	end

	assign rank = CNT_W'($countones(lt_vec));
	assign hit  = rank == (count_q >> 1);

	// ------------------------------------------------------------------
	// Percent mapping: clamp at both ends, divide in between
	// ------------------------------------------------------------------
	logic              at_full;
	logic              at_empty;
	logic [NUM_W-1:0]  div_num;
	logic              div_start;
	logic [QUOT_W-1:0] div_quot;
	div_status_t       div_st;

	assign at_full   = med_q >= full_q;
	assign at_empty  = med_q <= empty_q;
	assign div_num   = NUM_W'(NUM_W'(full_q - med_q) * NUM_W'(PCT_FULL));
	assign div_start = (state_q == S_PCT) & ~at_full & ~at_empty;

	emfl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (full_q),
		.quot   (div_quot),
		.status (div_st)
	);

	// ------------------------------------------------------------------
	// Post gate: large enough change, or long enough since the last post
	// ------------------------------------------------------------------
	logic [LAST_W-1:0] pct_ext;
	logic [LAST_W-1:0] pct_diff;
	logic              big_change;
	logic              time_ok;
	logic              post;
	logic              out_free;
	logic              load_level;

	assign pct_ext    = LAST_W'(pct_q);
	assign pct_diff   = (pct_ext > last_pct_q) ? pct_ext - last_pct_q : last_pct_q - pct_ext;
	assign big_change = pct_diff >= LAST_W'(deadband_q);
	assign time_ok    = elapsed_q >= TIME_W'(interval_q);
	assign post       = big_change | time_ok;
	assign out_free   = ~level_valid_q | ~level_stall;
	assign load_level = (state_q == S_DECIDE) & post & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sample_q      <= '0;
			prod1_s1      <= '0;
			prod2_s2      <= '0;
			elapsed_q     <= '0;
			count_q       <= '0;
			k_q           <= '0;
			med_q         <= '0;
			pct_q         <= '0;
			last_pct_q    <= LAST_PCT_RST;
			last_time_q   <= '0;
			level_valid_q <= 1'b0;
			level_q       <= '0;
		end else begin
			// raise the output word on a post, drop it once taken
			if (load_level) begin
				level_valid_q <= 1'b1;
			end else if (level_valid_q && !level_stall) begin
				level_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sample_q <= sample;
						state_q  <= S_CONV1;
					end
				end
				S_CONV1: begin
					prod1_s1  <= PROD1_W'(sample_q.echo_width_us) * PROD1_W'(ECHO_MUL);
					// last_time_q only moves at a post, so this holds until the gate
					elapsed_q <= sample_q.now_us - last_time_q;
					state_q   <= S_CONV2;
				end
				S_CONV2: begin
					prod2_s2 <= PROD2_W'(prod1_s1[PROD1_W-1:PRE_SH]) * PROD2_W'(RECIP);
					state_q  <= S_STORE;
				end
				S_STORE: begin
					// cells shift in dist_sat on this edge
					count_q <= count_next;
					k_q     <= '0;
					state_q <= enough ? S_RANK : S_IDLE;
				end
				S_RANK: begin
					if (hit) begin
						med_q   <= cand;
						state_q <= S_PCT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_PCT: begin
					if (at_full) begin
						pct_q   <= '0;
						state_q <= S_DECIDE;
					end else if (at_empty) begin
						pct_q   <= PCT_FULL;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						pct_q   <= div_quot;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!post) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						// post once the output is free; until then hold here while an earlier word still waits downstream
						level_q     <= '{fill_pct: pct_q, median_cm: med_q};
						last_pct_q  <= pct_ext;
						last_time_q <= sample_q.now_us;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign level_valid = level_valid_q;
	assign level       = level_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RANK) |-> (CNT_W'(k_q) < count_q))
		else $error("rank scan ran past the stored words");

	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_st.busy || div_st.done))
		else $error("waiting on an idle divider");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid |-> (level.fill_pct <= PCT_FULL))
		else $error("fill percent above 100");

endmodule
